@@ sv/assert_macros.svh @@
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  `ASSERT_CLK(lbl, clk, rstn, !(cond), msg)

`endif

@@ sv/rrlp_pkg.sv @@
// Package with the types, constants and helpers of the range line presence block.
`timescale 1ns / 1ps

package rrlp_pkg;

  localparam int unsigned TenthsW = 16;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned HoldW   = 7;
  localparam int unsigned HoldMsW = 22;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDatW = 32;

  localparam logic [TimeW-1:0]   GapLimitMs = 32'd100;
  localparam logic [HoldMsW-1:0] HoldUnitMs = 22'd30000;
  localparam logic [TenthsW-1:0] TenthsMax  = 16'hFFFF;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegMinRange   = 8'd0;
  localparam logic [CfgIdxW-1:0] RegMaxRange   = 8'd1;
  localparam logic [CfgIdxW-1:0] RegHoldUnits  = 8'd2;
  localparam logic [CfgIdxW-1:0] RegMaxAbsence = 8'd3;

  localparam logic [TenthsW-1:0] MinRangeRst   = 16'd0;
  localparam logic [TenthsW-1:0] MaxRangeRst   = 16'hFFFF;
  localparam logic [HoldMsW-1:0] HoldMsRst     = 22'd30000;
  localparam logic [TimeW-1:0]   MaxAbsenceRst = 32'd60000;

  // Opcodes of an input item.
  localparam logic OpByte = 1'b0;
  localparam logic OpPoll = 1'b1;

  // Characters the parser looks at.
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;

  localparam logic [2:0] PrefixLen = 3'd6;

  typedef enum logic [6:0] {
    PhSkip   = 7'b0000001,
    PhPrefix = 7'b0000010,
    PhSeek   = 7'b0000100,
    PhInt    = 7'b0001000,
    PhFrac   = 7'b0010000,
    PhDone   = 7'b0100000,
    PhReject = 7'b1000000
  } rrlp_phase_e;

  // One step of the parser, issued when an item leaves the input register.
  typedef struct packed {
    logic             en;
    logic             is_byte;
    logic [7:0]       rx_byte;
    logic [TimeW-1:0] now_ms;
  } rrlp_step_t;

  typedef struct packed {
    logic               valid;
    logic [TenthsW-1:0] tenths;
  } rrlp_res_t;

  // The text "Range " one character at a time.
  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h52;
      3'd1:    ch = 8'h61;
      3'd2:    ch = 8'h6E;
      3'd3:    ch = 8'h67;
      3'd4:    ch = 8'h65;
      3'd5:    ch = 8'h20;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

@@ sv/rrlp_if.sv @@
// Handshake interfaces for the input, result and configuration channels.
`timescale 1ns / 1ps

interface rrlp_in_if;
  logic                           valid;
  logic                           ready;
  logic                           opcode;
  logic [7:0]                     rx_byte;
  logic [rrlp_pkg::TimeW-1:0]     now_ms;

  modport source (output valid, opcode, rx_byte, now_ms, input ready);
  modport sink   (input valid, opcode, rx_byte, now_ms, output ready);
endinterface

interface rrlp_out_if;
  logic                           valid;
  logic                           ready;
  logic                           distance_valid;
  logic [rrlp_pkg::TenthsW-1:0]   distance_tenths;
  logic                           presence;

  modport source (output valid, distance_valid, distance_tenths, presence, input ready);
  modport sink   (input valid, distance_valid, distance_tenths, presence, output ready);
endinterface

interface rrlp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rrlp_pkg::CfgIdxW-1:0]   index;
  logic [rrlp_pkg::CfgDatW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/rrlp_parser.sv @@
// Line parser: gap timeout, whitespace skip, prefix match and decimal accumulation.
`timescale 1ns / 1ps

module rrlp_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rrlp_pkg::rrlp_step_t step_i,
  output rrlp_pkg::rrlp_res_t  res_o
);

  rrlp_pkg::rrlp_phase_e phase_q, phase_d;
  logic [2:0]                     pidx_q, pidx_d;
  logic [rrlp_pkg::TenthsW-1:0]   acc_q, acc_d;
  logic                           pend_q, pend_d;
  logic [rrlp_pkg::TimeW-1:0]     lbt_q, lbt_d;

  logic [rrlp_pkg::TimeW-1:0]     gap;
  logic                           is_blank, is_digit;
  logic [3:0]                     digit;
  logic [19:0]                    int_sum;
  logic [16:0]                    frac_sum;

  assign gap      = step_i.now_ms - lbt_q;
  assign is_blank = (step_i.rx_byte == rrlp_pkg::ChSpace) || (step_i.rx_byte == rrlp_pkg::ChTab)
                 || (step_i.rx_byte == rrlp_pkg::ChCr) || (step_i.rx_byte == rrlp_pkg::ChLf);
  assign is_digit = (step_i.rx_byte >= rrlp_pkg::ChZero) && (step_i.rx_byte <= rrlp_pkg::ChNine);
  assign digit    = 4'(step_i.rx_byte - rrlp_pkg::ChZero);

  // The integer and fraction phases are never reached right after a restart,
  // so the stored accumulator is the one they extend.
  assign int_sum  = 20'(acc_q) * 20'd10 + 20'(digit) * 20'd10;
  assign frac_sum = 17'(acc_q) + 17'(digit);

  always_comb begin
    phase_d = phase_q;
    pidx_d  = pidx_q;
    acc_d   = acc_q;
    pend_d  = pend_q;
    lbt_d   = lbt_q;
    res_o   = '0;
    if (step_i.is_byte) begin
      if ((gap > rrlp_pkg::GapLimitMs) && pend_q) begin
        phase_d = rrlp_pkg::PhSkip;
        pidx_d  = '0;
        acc_d   = '0;
      end
      lbt_d  = step_i.now_ms;
      pend_d = 1'b1;
      if (step_i.rx_byte == rrlp_pkg::ChLf) begin
        if ((phase_d == rrlp_pkg::PhInt) || (phase_d == rrlp_pkg::PhFrac)
            || (phase_d == rrlp_pkg::PhDone)) begin
          res_o.valid  = 1'b1;
          res_o.tenths = acc_d;
        end
        phase_d = rrlp_pkg::PhSkip;
        pidx_d  = '0;
        acc_d   = '0;
        pend_d  = 1'b0;
      end else begin
        if ((phase_d == rrlp_pkg::PhSkip) && !is_blank) begin
          phase_d = rrlp_pkg::PhPrefix;
          pidx_d  = '0;
        end
        unique case (phase_d)
          rrlp_pkg::PhPrefix: begin
            if ((pidx_d < rrlp_pkg::PrefixLen)
                && (step_i.rx_byte == rrlp_pkg::prefix_char(pidx_d))) begin
              pidx_d = pidx_d + 3'd1;
              if (pidx_d == rrlp_pkg::PrefixLen) begin
                phase_d = rrlp_pkg::PhSeek;
              end
            end else begin
              phase_d = rrlp_pkg::PhReject;
            end
          end
          rrlp_pkg::PhSeek: begin
            if (is_digit) begin
              acc_d   = 16'(digit) * 16'd10;
              phase_d = rrlp_pkg::PhInt;
            end
          end
          rrlp_pkg::PhInt: begin
            if (is_digit) begin
              acc_d = (int_sum > 20'(rrlp_pkg::TenthsMax)) ? rrlp_pkg::TenthsMax
                                                           : int_sum[15:0];
            end else if (step_i.rx_byte == rrlp_pkg::ChDot) begin
              phase_d = rrlp_pkg::PhFrac;
            end else begin
              phase_d = rrlp_pkg::PhDone;
            end
          end
          rrlp_pkg::PhFrac: begin
            if (is_digit) begin
              acc_d = frac_sum[16] ? rrlp_pkg::TenthsMax : frac_sum[15:0];
            end
            phase_d = rrlp_pkg::PhDone;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= rrlp_pkg::PhSkip;
      pidx_q  <= '0;
      acc_q   <= '0;
      pend_q  <= 1'b0;
      lbt_q   <= '0;
    end else if (step_i.en) begin
      phase_q <= phase_d;
      pidx_q  <= pidx_d;
      acc_q   <= acc_d;
      pend_q  <= pend_d;
      lbt_q   <= lbt_d;
    end
  end

endmodule

@@ sv/radar_range_line_presence.sv @@
// Range line parser with presence decision: top level with channels and registers.
// An item passes through the input register and then the output register; a result
// is held in the output register until the receiver takes it.
// Throughput: one item per cycle while the receiver does not stall; the parser state
// and the activity time are both updated in the single cycle in which an item leaves
// the input register. Reset is asynchronous and active low; it restores the register
// defaults and clears the parser, both timestamps and both pipeline stages.
`timescale 1ns / 1ps

module radar_range_line_presence (
  input  logic       clk_i,
  input  logic       rst_ni,
  rrlp_in_if.sink    in_i,
  rrlp_out_if.source out_o,
  rrlp_cfg_if.sink   cfg_i
);

  logic [rrlp_pkg::TenthsW-1:0] min_range_q;
  logic [rrlp_pkg::TenthsW-1:0] max_range_q;
  logic [rrlp_pkg::HoldMsW-1:0] hold_ms_q;
  logic [rrlp_pkg::TimeW-1:0]   max_abs_q;

  logic                         s1_valid_q;
  logic                         s1_op_q;
  logic [7:0]                   s1_byte_q;
  logic [rrlp_pkg::TimeW-1:0]   s1_now_q;

  logic                         out_valid_q;
  logic                         dist_valid_q;
  logic [rrlp_pkg::TenthsW-1:0] dist_q;
  logic                         pres_q, pres_d;

  logic [rrlp_pkg::TimeW-1:0]   act_q, act_d;
  logic [rrlp_pkg::TimeW-1:0]   elapsed;
  logic                         advance;
  logic                         in_fire;
  logic                         cfg_fire;
  logic                         in_window;

  rrlp_pkg::rrlp_step_t step;
  rrlp_pkg::rrlp_res_t  res;

  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid;

  // The hold time is scaled once when written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_range_q <= rrlp_pkg::MinRangeRst;
      max_range_q <= rrlp_pkg::MaxRangeRst;
      hold_ms_q   <= rrlp_pkg::HoldMsRst;
      max_abs_q   <= rrlp_pkg::MaxAbsenceRst;
    end else if (cfg_fire) begin
      unique case (cfg_i.index)
        rrlp_pkg::RegMinRange:   min_range_q <= cfg_i.data[rrlp_pkg::TenthsW-1:0];
        rrlp_pkg::RegMaxRange:   max_range_q <= cfg_i.data[rrlp_pkg::TenthsW-1:0];
        rrlp_pkg::RegHoldUnits:  hold_ms_q   <= rrlp_pkg::HoldMsW'(cfg_i.data[rrlp_pkg::HoldW-1:0])
                                                * rrlp_pkg::HoldUnitMs;
        rrlp_pkg::RegMaxAbsence: max_abs_q   <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  assign advance    = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || advance;
  assign in_fire    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_op_q   <= in_i.opcode;
      s1_byte_q <= in_i.rx_byte;
      s1_now_q  <= in_i.now_ms;
    end
  end

  assign step.en      = advance;
  assign step.is_byte = (s1_op_q == rrlp_pkg::OpByte);
  assign step.rx_byte = s1_byte_q;
  assign step.now_ms  = s1_now_q;

  rrlp_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .res_o  (res)
  );

  assign in_window = res.valid && (res.tenths >= min_range_q) && (res.tenths <= max_range_q);
  assign act_d     = in_window ? s1_now_q : act_q;
  assign elapsed   = s1_now_q - act_d;
  assign pres_d    = (elapsed < rrlp_pkg::TimeW'(hold_ms_q)) && !(elapsed > max_abs_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        act_q       <= act_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      dist_valid_q <= res.valid;
      dist_q       <= res.tenths;
      pres_q       <= pres_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.distance_valid  = dist_valid_q;
  assign out_o.distance_tenths = dist_q;
  assign out_o.presence        = pres_q;

endmodule

@@ sv/rrlp_checker.sv @@
// Port-level checker for the range line presence block, with its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rrlp_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic                         dist_valid_i,
  input logic [rrlp_pkg::TenthsW-1:0] dist_tenths_i
);

  logic [1:0] cnt_q;
  logic       in_fire, out_fire;

  assign in_fire  = in_valid_i && in_ready_i;
  assign out_fire = out_valid_i && out_ready_i;

  // Items accepted but not yet delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + 2'(in_fire) - 2'(out_fire);
    end
  end

  `ASSERT_NEVER(a_depth, clk_i, rst_ni, cnt_q == 2'd3, "more than two items in flight")
  `ASSERT_NEVER(a_no_phantom, clk_i, rst_ni, out_valid_i && (cnt_q == 2'd0), "result without item")
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, (out_valid_i && !out_ready_i) |=> out_valid_i,
              "stalled result dropped")
  `ASSERT_CLK(a_zero_dist, clk_i, rst_ni,
              (out_valid_i && !dist_valid_i) |-> (dist_tenths_i == '0),
              "distance nonzero without a line")

endmodule

bind radar_range_line_presence rrlp_checker u_rrlp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .dist_valid_i  (out_o.distance_valid),
  .dist_tenths_i (out_o.distance_tenths)
);

@@ sim/testbench.sv @@
// Self-checking testbench of the range line parser with presence decision.
`timescale 1ns / 1ps

module testbench;
  import rrlp_pkg::*;

  localparam int unsigned StallLimit = 5000;
  localparam int unsigned HoldoffCycles = 400;
  localparam int unsigned ItemsPerPhase = 240;
  localparam logic [CfgIdxW-1:0] RegUnused = 8'hFF;
  localparam logic [47:0] RangeTag = "Range ";
  localparam logic [39:0] JunkSet = "+-.xe";

  typedef struct packed {
    logic             op;
    logic [7:0]       rx;
    logic [TimeW-1:0] now;
  } radar_item_t;

  typedef struct packed {
    logic               dv;
    logic [TenthsW-1:0] tenths;
    logic               pres;
  } radar_report_t;

  typedef struct {
    radar_item_t   item;
    logic          pinned;
    radar_report_t rep;
  } smoke_row_t;

  logic clk_i;
  logic rst_ni;

  rrlp_in_if  in_if ();
  rrlp_out_if out_if ();
  rrlp_cfg_if cfg_if ();

  radar_range_line_presence dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // Register copies of the predictor.
  logic [TenthsW-1:0] cfg_min_tenths;
  logic [TenthsW-1:0] cfg_max_tenths;
  logic [HoldW-1:0]   cfg_hold_units;
  logic [TimeW-1:0]   cfg_max_absence;

  // Parser and timing state of the predictor.
  logic [TimeW-1:0]   pm_last_byte_ms;
  logic [TimeW-1:0]   pm_last_activity_ms;
  rrlp_phase_e        pm_phase;
  int unsigned        pm_prefix_idx;
  logic [TenthsW-1:0] pm_accum;
  logic               pm_line_open;

  radar_report_t pending_reports[$];
  smoke_row_t    smoke_rows[$];

  int unsigned gap_pct;
  int unsigned stall_pct;
  logic        holdoff_req;
  int unsigned holdoff_left;
  int unsigned items_sent;
  int unsigned fail_count;
  int unsigned idle_cycles;
  logic [TimeW-1:0] sim_ms;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic logic [7:0] tag_char(input int unsigned idx);
    return RangeTag[47 - 8 * idx -: 8];
  endfunction

  function automatic logic is_blank(input logic [7:0] ch);
    return ch == ChSpace || ch == ChTab || ch == ChCr || ch == ChLf;
  endfunction

  function automatic logic is_digit(input logic [7:0] ch);
    return ch >= ChZero && ch <= ChNine;
  endfunction

  function automatic void restart_parse();
    pm_phase      = PhSkip;
    pm_prefix_idx = 0;
    pm_accum      = '0;
    pm_line_open  = 1'b0;
  endfunction

  function automatic void reset_predictor();
    cfg_min_tenths      = 16'd0;
    cfg_max_tenths      = 16'hFFFF;
    cfg_hold_units      = 7'd1;
    cfg_max_absence     = 32'd60000;
    pm_last_byte_ms     = '0;
    pm_last_activity_ms = '0;
    restart_parse();
  endfunction

  function automatic void apply_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] val);
    case (idx)
      RegMinRange:   cfg_min_tenths  = val[TenthsW-1:0];
      RegMaxRange:   cfg_max_tenths  = val[TenthsW-1:0];
      RegHoldUnits:  cfg_hold_units  = val[HoldW-1:0];
      RegMaxAbsence: cfg_max_absence = val[TimeW-1:0];
      default: ;
    endcase
  endfunction

  // Advances the parser by one item and works out its report.
  function automatic radar_report_t predict_report(input radar_item_t it);
    radar_report_t    rep;
    logic [TimeW-1:0] elapsed;
    logic [TimeW-1:0] hold_ms;
    int unsigned      sum;
    int unsigned      digit;
    rep   = '0;
    digit = int'(it.rx) - int'(ChZero);
    if (it.op == OpByte) begin
      if ((it.now - pm_last_byte_ms) > GapLimitMs && pm_line_open) restart_parse();
      pm_last_byte_ms = it.now;
      pm_line_open    = 1'b1;
      if (it.rx == ChLf) begin
        if (pm_phase == PhInt || pm_phase == PhFrac || pm_phase == PhDone) begin
          rep.dv     = 1'b1;
          rep.tenths = pm_accum;
          if (pm_accum >= cfg_min_tenths && pm_accum <= cfg_max_tenths)
            pm_last_activity_ms = it.now;
        end
        restart_parse();
      end else begin
        if (pm_phase == PhSkip && !is_blank(it.rx)) begin
          pm_phase      = PhPrefix;
          pm_prefix_idx = 0;
        end
        case (pm_phase)
          PhPrefix: begin
            if (pm_prefix_idx < 6 && it.rx == tag_char(pm_prefix_idx)) begin
              pm_prefix_idx++;
              if (pm_prefix_idx == 6) pm_phase = PhSeek;
            end else begin
              pm_phase = PhReject;
            end
          end
          PhSeek: begin
            if (is_digit(it.rx)) begin
              pm_accum = 16'(digit * 10);
              pm_phase = PhInt;
            end
          end
          PhInt: begin
            if (is_digit(it.rx)) begin
              sum      = int'(pm_accum) * 10 + digit * 10;
              pm_accum = (sum > 65535) ? TenthsMax : 16'(sum);
            end else if (it.rx == ChDot) begin
              pm_phase = PhFrac;
            end else begin
              pm_phase = PhDone;
            end
          end
          PhFrac: begin
            if (is_digit(it.rx)) begin
              sum      = int'(pm_accum) + digit;
              pm_accum = (sum > 65535) ? TenthsMax : 16'(sum);
            end
            pm_phase = PhDone;
          end
          default: ;
        endcase
      end
    end
    elapsed  = it.now - pm_last_activity_ms;
    hold_ms  = 32'(cfg_hold_units) * 32'(HoldUnitMs);
    rep.pres = (elapsed < hold_ms) && !(elapsed > cfg_max_absence);
    return rep;
  endfunction

  // Offers one item, with random idle cycles ahead of it, and records what it must produce.
  task automatic offer_item(input radar_item_t it, input logic pinned,
                            input radar_report_t pinned_rep);
    radar_report_t rep;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid   = 1'b1;
    in_if.opcode  = it.op;
    in_if.rx_byte = it.rx;
    in_if.now_ms  = it.now;
    do @(posedge clk_i); while (!in_if.ready);
    rep = predict_report(it);
    pending_reports.insert(pending_reports.size(), pinned ? pinned_rep : rep);
    items_sent++;
    @(negedge clk_i);
    // The item has been taken; a following offer raises valid again at this same edge.
    in_if.valid = 1'b0;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDatW-1:0] val);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = val;
    do @(posedge clk_i); while (!cfg_if.ready);
    apply_reg(idx, val);
    @(negedge clk_i);
  endtask

  task automatic drain_reports();
    while (pending_reports.size() != 0) @(negedge clk_i);
  endtask

  // Sends one byte of a line, sometimes after a poll, with a small or a timed-out gap.
  task automatic feed_byte(input logic [7:0] ch);
    radar_item_t it;
    if ($urandom_range(0, 9) == 0) begin
      sim_ms += $urandom_range(0, 50);
      it.op  = OpPoll;
      it.rx  = 8'($urandom_range(0, 255));
      it.now = sim_ms;
      offer_item(it, 1'b0, '0);
    end
    if ($urandom_range(0, 39) == 0) sim_ms += $urandom_range(101, 1000);
    else sim_ms += $urandom_range(0, 20);
    it.op  = OpByte;
    it.rx  = ch;
    it.now = sim_ms;
    offer_item(it, 1'b0, '0);
  endtask

  function automatic logic [7:0] pick_blank();
    logic [7:0] ch;
    case ($urandom_range(0, 3))
      0:       ch = ChSpace;
      1:       ch = ChTab;
      2:       ch = ChCr;
      default: ch = ChLf;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] pick_junk();
    return JunkSet[39 - 8 * $urandom_range(0, 4) -: 8];
  endfunction

  function automatic logic [7:0] pick_digit();
    return ChZero + 8'($urandom_range(0, 9));
  endfunction

  // Mostly well-formed range lines with random content; some noise and broken prefixes.
  task automatic send_random_line();
    logic [7:0]  text[$];
    int unsigned kind;
    int unsigned base;
    int unsigned ndig;
    int unsigned sel;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 2) sim_ms = $urandom();
    else if (r < 14) sim_ms += $urandom_range(0, 200000);
    else sim_ms += $urandom_range(0, 3000);
    kind = $urandom_range(0, 9);
    repeat ($urandom_range(0, 2)) text.insert(text.size(), pick_blank());
    if (kind == 0) begin
      repeat ($urandom_range(1, 8)) text.insert(text.size(), 8'($urandom_range(0, 255)));
    end else begin
      base = text.size();
      for (int i = 0; i < 6; i++) text.insert(text.size(), tag_char(i));
      if (kind == 1) text[base + $urandom_range(0, 5)] = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 3) == 0) text.insert(text.size(), pick_junk());
      sel = $urandom_range(0, 19);
      if (sel == 0) ndig = 0;
      else if (sel < 3) ndig = $urandom_range(5, 6);
      else ndig = $urandom_range(1, 4);
      repeat (ndig) text.insert(text.size(), pick_digit());
      if ($urandom_range(0, 1) == 0) begin
        text.insert(text.size(), ChDot);
        repeat ($urandom_range(0, 3)) text.insert(text.size(), pick_digit());
      end
      if ($urandom_range(0, 4) == 0) text.insert(text.size(), pick_junk());
    end
    if ($urandom_range(0, 15) != 0) text.insert(text.size(), ChLf);
    foreach (text[i]) feed_byte(text[i]);
  endtask

  task automatic run_phase(input logic [CfgDatW-1:0] min_val, input logic [CfgDatW-1:0] max_val,
                           input logic [CfgDatW-1:0] hold_val, input logic [CfgDatW-1:0] abs_val,
                           input int unsigned gap, input int unsigned stall,
                           input logic poke_unused, input logic long_holdoff);
    int unsigned start;
    // The sender waits here until the block has returned every pending result.
    drain_reports();
    write_reg(RegMinRange, min_val);
    write_reg(RegMaxRange, max_val);
    write_reg(RegHoldUnits, hold_val);
    write_reg(RegMaxAbsence, abs_val);
    if (poke_unused) write_reg(RegUnused, $urandom());
    cfg_if.valid = 1'b0;
    gap_pct   = gap;
    stall_pct = stall;
    if (long_holdoff) holdoff_req = 1'b1;
    start = items_sent;
    while (items_sent - start < ItemsPerPhase) send_random_line();
  endtask

  function automatic void add_row(input logic op, input logic [7:0] rx, input logic [TimeW-1:0] now,
                                  input logic pinned, input logic dv,
                                  input logic [TenthsW-1:0] tenths, input logic pres);
    smoke_row_t row;
    row.item.op    = op;
    row.item.rx    = rx;
    row.item.now   = now;
    row.pinned     = pinned;
    row.rep.dv     = dv;
    row.rep.tenths = tenths;
    row.rep.pres   = pres;
    smoke_rows.insert(smoke_rows.size(), row);
  endfunction

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    out_if.ready = 1'b0;
    holdoff_left = 0;
    forever begin
      @(negedge clk_i);
      if (holdoff_req) begin
        holdoff_req  = 1'b0;
        holdoff_left = HoldoffCycles;
      end
      if (holdoff_left > 0) begin
        out_if.ready = 1'b0;
        holdoff_left--;
      end else begin
        out_if.ready = ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    radar_report_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_reports.size() == 0) begin
        $error("result item arrived with no expectation waiting");
        fail_count++;
      end else begin
        want = pending_reports.pop_front();
        if (out_if.distance_valid !== want.dv) begin
          $error("distance_valid: expected %0d, got %0d", want.dv, out_if.distance_valid);
          fail_count++;
        end
        if (out_if.distance_tenths !== want.tenths) begin
          $error("distance_tenths: expected %0d, got %0d", want.tenths, out_if.distance_tenths);
          fail_count++;
        end
        if (out_if.presence !== want.pres) begin
          $error("presence: expected %0d, got %0d", want.pres, out_if.presence);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles in which no channel moves an item.
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] digits;
    rst_ni         = 1'b0;
    in_if.valid    = 1'b0;
    in_if.opcode   = OpByte;
    in_if.rx_byte  = '0;
    in_if.now_ms   = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = '0;
    cfg_if.data    = '0;
    gap_pct        = 0;
    stall_pct      = 0;
    holdoff_req    = 1'b0;
    items_sent     = 0;
    fail_count     = 0;
    idle_cycles    = 0;
    sim_ms         = '0;
    digits         = "6554";
    reset_predictor();

    // Directed rows; pinned ones carry their report as typed in.
    add_row(OpPoll, 8'h00, 32'd0,     1'b1, 1'b0, 16'd0, 1'b1);
    add_row(OpPoll, 8'h00, 32'd30000, 1'b1, 1'b0, 16'd0, 1'b0);   // hold time reached exactly
    add_row(OpByte, 8'hFF, 32'd10,    1'b0, 1'b0, 16'd0, 1'b0);
    add_row(OpByte, ChLf,  32'd20,    1'b1, 1'b0, 16'd0, 1'b1);   // line without the prefix
    add_row(OpByte, ChSpace, 32'd25,  1'b0, 1'b0, 16'd0, 1'b0);
    add_row(OpByte, ChLf,  32'd26,    1'b1, 1'b0, 16'd0, 1'b1);   // whitespace-only line
    add_row(OpByte, ChCr,  32'd30,    1'b0, 1'b0, 16'd0, 1'b0);
    for (int i = 0; i < 6; i++)
      add_row(OpByte, tag_char(i), 32'd31 + i, 1'b0, 1'b0, 16'd0, 1'b0);
    for (int i = 0; i < 4; i++)
      add_row(OpByte, digits[31 - 8 * i -: 8], 32'd37 + i, 1'b0, 1'b0, 16'd0, 1'b0);
    add_row(OpByte, ChLf,  32'd41,    1'b1, 1'b1, TenthsMax, 1'b1); // saturated distance
    add_row(OpByte, tag_char(0), 32'd42, 1'b0, 1'b0, 16'd0, 1'b0);
    add_row(OpByte, 8'h00, 32'd300,   1'b0, 1'b0, 16'd0, 1'b0);   // gap timeout restarts the line
    add_row(OpByte, ChLf,  32'd301,   1'b1, 1'b0, 16'd0, 1'b1);
    add_row(OpPoll, 8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 16'd0, 1'b0);

    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (smoke_rows[i]) offer_item(smoke_rows[i].item, smoke_rows[i].pinned, smoke_rows[i].rep);

    sim_ms = 32'd1000;
    run_phase(32'd0, 32'd65535, 32'd1, 32'd60000, 0, 0, 1'b0, 1'b0);
    run_phase(32'd100, 32'd3000, 32'd2, 32'd100000, 55, 0, 1'b0, 1'b0);
    run_phase(32'd0, 32'd0, 32'd0, 32'd0, 0, 55, 1'b0, 1'b0);
    run_phase(32'd65535, 32'd65535, 32'd100, 32'hFFFF_FFFF, 32, 32, 1'b0, 1'b0);
    run_phase($urandom_range(0, 2000), $urandom_range(2000, 65535), $urandom_range(0, 100),
              $urandom(), 0, 0, 1'b0, 1'b1);
    run_phase(32'd5000, 32'd10, 32'd127, $urandom_range(0, 400000), 55, 0, 1'b0, 1'b0);
    run_phase($urandom(), $urandom(), $urandom(), $urandom(), 0, 55, 1'b1, 1'b0);
    sim_ms = 32'hFFFF_F000;
    run_phase($urandom_range(0, 500), $urandom_range(500, 65535), $urandom_range(1, 100),
              $urandom_range(30000, 3000000), 32, 32, 1'b0, 1'b0);

    in_if.valid = 1'b0;
    drain_reports();
    repeat (8) @(negedge clk_i);
    if (pending_reports.size() != 0) begin
      $error("%0d expected result items never arrived", pending_reports.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
